// ===== rtl/ash_pkg.sv =====
// ash_pkg: shared types and constants for the adc sample histogram
// used by ash_sat_inc and adc_sample_histogram_unit; no dependencies
`default_nettype none

package ash_pkg;

  // default geometry of the histogram store
  localparam int unsigned NUM_BINS_DEF    = 2048;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // widths fixed by the item and result formats
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned LIMIT_W  = 16;

  // command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // reset value of the count limit register
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'hFFFF;

  // one command item
  typedef struct packed {
    logic                command;
    logic [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]  bin_index;
  } item_t;

  // one result item
  typedef struct packed {
    logic [OUT_W-1:0] bin_count;
    logic             overflow;
  } result_t;

  // decision of the saturating increment unit
  typedef struct packed {
    logic hit;  // add found its bin at the limit
    logic wr;   // add may write the incremented count back
  } upd_ctl_t;

endpackage : ash_pkg

`default_nettype wire

// ===== rtl/ash_sat_inc.sv =====
// ash_sat_inc: shared compare and increment unit for one bin count
// depends on ash_pkg for the limit width and the decision struct
`default_nettype none

module ash_sat_inc #(
  parameter int unsigned COUNT_WIDTH = ash_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          is_add_i,
  input  wire logic [COUNT_WIDTH-1:0]        cnt_i,
  input  wire logic [ash_pkg::LIMIT_W-1:0]   limit_i,
  output      logic [COUNT_WIDTH-1:0]        cnt_next_o,
  output      ash_pkg::upd_ctl_t             ctl_o
);
  import ash_pkg::*;

  logic at_limit;

  // a bin at or above the limit, or at its widest value, stays put
  always_comb begin
    at_limit       = (32'(cnt_i) >= 32'(limit_i)) || (&cnt_i);
    ctl_o.hit      = is_add_i && at_limit;
    ctl_o.wr       = is_add_i && !at_limit;
    cnt_next_o     = cnt_i + COUNT_WIDTH'(1);
  end

endmodule : ash_sat_inc

`default_nettype wire

// ===== rtl/adc_sample_histogram_unit.sv =====
// adc_sample_histogram_unit: saturating histogram of adc samples, top level
// depends on ash_pkg and ash_sat_inc; holds the bin store and the sequencer
//
//   port group         dir  handshake             payload
//   command            in   start_i / busy_o      item_i (ash_pkg::item_t)
//   result             out  result_valid_o        result_o (ash_pkg::result_t)
//   count limit        in   cfg_we_i              cfg_data_i
//
// an item is handled as a read of the bin store, then an update step with the compare,
// and for an add below the limit the increment and write-back through the single store port
// the result strobe comes the cycle after the update step; busy_o is low again then
// after reset a clearing pass writes zero to every bin in turn,
// with busy_o high; limit writes are taken as ever
// the receiver cannot stall: each result is shown for one cycle only
`default_nettype none

module adc_sample_histogram_unit #(
  parameter int unsigned NUM_BINS    = ash_pkg::NUM_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = ash_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire ash_pkg::item_t               item_i,
  output      logic                         busy_o,
  output      logic                         result_valid_o,
  output      ash_pkg::result_t             result_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [ash_pkg::LIMIT_W-1:0]  cfg_data_i
);
  import ash_pkg::*;

  localparam int unsigned BinW       = $clog2(NUM_BINS);
  localparam logic [BinW-1:0] TopBin = BinW'(NUM_BINS - 1);
  localparam logic [31:0] TopBinWide = 32'(NUM_BINS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_e;

  state_e                 state_q;
  logic [BinW-1:0]        clr_addr_q;
  logic [LIMIT_W-1:0]     limit_q;
  logic                   overflow_q;
  logic                   result_valid_q;
  result_t                result_q;

  logic [COUNT_WIDTH-1:0] mem_q [NUM_BINS];
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic [BinW-1:0]        addr_q;
  logic                   is_add_q;

  logic                   accept;
  logic [31:0]            sel_wide;
  logic [BinW-1:0]        sel_addr;
  logic                   mem_we;
  logic [BinW-1:0]        mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [COUNT_WIDTH-1:0] cnt_next;
  logic [COUNT_WIDTH-1:0] cnt_out;
  upd_ctl_t               upd_ctl;

  // command transfer and bin selection with clamp to the top bin
  always_comb begin
    accept   = start_i && (state_q == ST_IDLE);
    sel_wide = (item_i.command == CMD_READ) ? 32'(item_i.bin_index)
                                            : 32'(item_i.sample);
    sel_addr = (sel_wide > TopBinWide) ? TopBin : sel_wide[BinW-1:0];
  end

  // shared saturating increment
  ash_sat_inc #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_sat_inc (
    .is_add_i   (is_add_q),
    .cnt_i      (rd_data_q),
    .limit_i    (limit_q),
    .cnt_next_o (cnt_next),
    .ctl_o      (upd_ctl)
  );

  // store write port: clearing pass or write-back
  always_comb begin
    mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_UPDATE) && upd_ctl.wr);
    mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : addr_q;
    mem_wdata = (state_q == ST_CLEAR) ? '0 : cnt_next;
    cnt_out   = upd_ctl.wr ? cnt_next : rd_data_q;
  end

  // bin store with registered read, plus item payload
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data_q <= mem_q[sel_addr];
      addr_q    <= sel_addr;
      is_add_q  <= (item_i.command == CMD_ADD);
    end
  end

  // sequencer, sticky flag, limit register and result outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_addr_q     <= '0;
      limit_q        <= LIMIT_RST;
      overflow_q     <= 1'b0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      result_valid_q <= 1'b0;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + BinW'(1);
          if (clr_addr_q == TopBin) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          overflow_q         <= overflow_q | upd_ctl.hit;
          result_q.bin_count <= OUT_W'(cnt_out);
          result_q.overflow  <= overflow_q | upd_ctl.hit;
          result_valid_q     <= 1'b1;
          state_q            <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // a result strobe always follows an update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_UPDATE))
    else $error("result strobe without a preceding update");

  // every command transfer yields a result strobe after its update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 result_valid_o)
    else $error("command transfer produced no result");

  // the overflow flag never drops outside reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(overflow_q) |-> overflow_q)
    else $error("sticky overflow flag cleared");

  // the reported flag matches the sticky register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.overflow == overflow_q))
    else $error("reported overflow differs from sticky flag");

endmodule : adc_sample_histogram_unit

`default_nettype wire
